@@ design/pct_pkg.sv @@
// pct_pkg: shared types, codes and constants for the preset countdown timer.
// No dependencies; used by every design file.
`timescale 1ns / 1ps

package pct_pkg;

  localparam int PRESET_COUNT = 3;

  localparam int NOW_W  = 48;
  localparam int LEFT_W = 26;
  localparam int SEC_W  = 16;
  localparam int SEL_W  = 2;

  localparam int MS_PER_S = 1000;
  localparam logic [LEFT_W-1:0] LEFT_CAP  = 26'd65535000;
  localparam logic [LEFT_W-1:0] CEIL_BIAS = 26'd999;

  // floor(z / 125) = (z * RECIP_125) >> RECIP_SHIFT, exact for z < 2^23
  localparam logic [23:0] RECIP_125   = 24'd8589935;
  localparam int          RECIP_SHIFT = 30;

  localparam logic [SEC_W-1:0] RST_PRESET_A = 16'd60;
  localparam logic [SEC_W-1:0] RST_PRESET_B = 16'd180;
  localparam logic [SEC_W-1:0] RST_PRESET_C = 16'd300;
  localparam logic [SEC_W-1:0] RST_ADDED    = 16'd60;
  localparam logic [SEC_W-1:0] RST_MAXIMUM  = 16'd5999;
  localparam logic [SEC_W-1:0] RST_INTERVAL = 16'd1000;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_DOWN,
    OP_UP,
    OP_CONFIRM
  } opcode_t;

  typedef enum logic [1:0] {
    PH_SELECT,
    PH_RUN,
    PH_PAUSE,
    PH_ALARM
  } phase_t;

  typedef enum logic [2:0] {
    NT_NONE,
    NT_PRESET,
    NT_STARTED,
    NT_ADJUSTED,
    NT_CANCELLED,
    NT_ACKED,
    NT_PAUSED,
    NT_RESUMED
  } notice_t;

  typedef enum logic [2:0] {
    CFG_PRESET_A,
    CFG_PRESET_B,
    CFG_PRESET_C,
    CFG_ADDED,
    CFG_MAXIMUM,
    CFG_INTERVAL
  } cfg_reg_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [NOW_W-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    phase_t             phase;
    logic [SEL_W-1:0]   preset_index;
    logic [SEC_W-1:0]   remaining_seconds;
    logic [SEC_W-1:0]   total_seconds;
    logic               progress_shown;
    logic               alarm_pulse;
    notice_t            notice;
  } result_t;

  typedef struct packed {
    logic [SEC_W-1:0]   preset_a_s;
    logic [SEC_W-1:0]   preset_b_s;
    logic [SEC_W-1:0]   preset_c_s;
    logic [SEC_W-1:0]   added_s;
    logic [SEC_W-1:0]   maximum_s;
    logic [SEC_W-1:0]   interval_ms;
    logic [LEFT_W-1:0]  added_ms;
    logic [LEFT_W-1:0]  maximum_ms;
  } settings_t;

  function automatic logic [LEFT_W-1:0] sec_to_ms(input logic [SEC_W-1:0] s);
    return LEFT_W'(s) * LEFT_W'(MS_PER_S);
  endfunction

endpackage

@@ design/preset_countdown_timer.sv @@
// preset_countdown_timer: top level, item and result registers and timer state update.
// Depends on pct_pkg and pct_cfg.
`timescale 1ns / 1ps

// Countdown timer driven by tick and button transactions stamped with a millisecond
// time; every accepted transaction yields exactly one result transaction. The block
// takes one transaction per clock cycle while item_stall is low. The accepting edge
// loads the input register and a later edge, once the result register is free, loads
// the result register. The timer state update between those two registers is
// combinational. A stalled result holds the pipeline, so item_stall rises only
// while a finished result is waiting and another transaction is already held.
// Configuration writes are taken in any cycle (cfg_ready is always high) and must be
// made while no transaction is in flight; indexes beyond the sixth register are ignored.

module preset_countdown_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  pct_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output pct_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  pct_pkg::cfg_reg_t           cfg_index,
  input  logic [pct_pkg::SEC_W-1:0]   cfg_data
);

  localparam int NW = pct_pkg::NOW_W;
  localparam int LW = pct_pkg::LEFT_W;
  localparam int SW = pct_pkg::SEC_W;
  localparam int PW = pct_pkg::SEL_W;

  function automatic logic [NW-1:0] sat_add(input logic [NW-1:0] a,
                                            input logic [NW-1:0] b);
    logic [NW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[NW] ? '1 : s[NW-1:0];
  endfunction

  // min(x, 2^48-1 - now): time left to a deadline that saturated
  function automatic logic [LW-1:0] clip_room(input logic [LW-1:0] x,
                                              input logic [NW-1:0] t);
    logic [NW-1:0] room;
    room = ~t;
    if (|room[NW-1:LW]) begin
      return x;
    end
    return (x < room[LW-1:0]) ? x : room[LW-1:0];
  endfunction

  function automatic logic [SW-1:0] ceil_sec(input logic [LW-1:0] ms);
    logic [LW-1:0] y;
    logic [LW-4:0] z;
    logic [46:0]   p;
    y = ms + pct_pkg::CEIL_BIAS;
    z = y[LW-1:3];
    p = 47'(z) * 47'(pct_pkg::RECIP_125);
    return p[pct_pkg::RECIP_SHIFT +: SW];
  endfunction

  pct_pkg::settings_t settings;

  pct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .settings  (settings)
  );

  // pipeline
  logic           stage_valid;
  pct_pkg::item_t stage_item;
  logic           advance;

  assign advance    = stage_valid && (!result_valid || !result_stall);
  assign item_stall = stage_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  // timer state
  pct_pkg::phase_t phase, phase_next;
  logic [PW-1:0]   preset_sel, preset_sel_next;
  logic [NW-1:0]   deadline_ms, deadline_ms_next;
  logic [LW-1:0]   paused_left_ms, paused_left_ms_next;
  logic [SW-1:0]   total_s, total_s_next;
  logic [NW-1:0]   next_pulse_ms, next_pulse_ms_next;
  logic [SW-1:0]   last_second, last_second_next;
  logic            last_second_valid, last_second_valid_next;

  pct_pkg::opcode_t op;
  logic [NW-1:0]    now;
  logic [NW-1:0]    diff;
  logic             run_live;
  logic [LW-1:0]    left_old;
  logic [LW:0]      add_sum;
  logic [LW-1:0]    x_add;
  logic [LW:0]      pause_sum;
  logic [LW-1:0]    pause_add;
  logic [SW:0]      total_sum;
  logic [SW-1:0]    total_add;
  logic [SW-1:0]    sel_secs;
  logic [SW-1:0]    shown_secs;
  logic [LW-1:0]    run_x;
  logic [NW-1:0]    deadline_set;
  logic [LW-1:0]    left_set;
  logic [NW-1:0]    pulse_set;
  logic [PW-1:0]    sel_dn, sel_up;
  logic [LW-1:0]    left_new;
  logic [SW-1:0]    remaining;
  logic             force_show;
  logic             tick_check;
  logic             progress_base;
  logic             pulse;
  pct_pkg::notice_t notice;
  logic             progress;

  always_comb begin
    op       = stage_item.opcode;
    now      = stage_item.now_ms;
    diff     = deadline_ms - now;
    run_live = (phase == pct_pkg::PH_RUN) && (now < deadline_ms);

    if (phase == pct_pkg::PH_PAUSE) begin
      left_old = paused_left_ms;
    end else if (run_live) begin
      left_old = (diff > NW'(pct_pkg::LEFT_CAP)) ? pct_pkg::LEFT_CAP : diff[LW-1:0];
    end else begin
      left_old = '0;
    end

    add_sum   = {1'b0, left_old} + {1'b0, settings.added_ms};
    x_add     = (add_sum > {1'b0, settings.maximum_ms}) ? settings.maximum_ms
                                                        : add_sum[LW-1:0];
    pause_sum = {1'b0, paused_left_ms} + {1'b0, settings.added_ms};
    pause_add = (pause_sum > {1'b0, settings.maximum_ms}) ? settings.maximum_ms
                                                          : pause_sum[LW-1:0];
    total_sum = {1'b0, total_s} + {1'b0, settings.added_s};
    total_add = (total_sum > {1'b0, settings.maximum_s}) ? settings.maximum_s
                                                         : total_sum[SW-1:0];

    case (preset_sel)
      PW'(0):  sel_secs = settings.preset_a_s;
      PW'(1):  sel_secs = settings.preset_b_s;
      default: sel_secs = settings.preset_c_s;
    endcase

    case (phase)
      pct_pkg::PH_SELECT: run_x = pct_pkg::sec_to_ms(sel_secs);
      pct_pkg::PH_RUN:    run_x = x_add;
      default:            run_x = paused_left_ms;
    endcase

    deadline_set = sat_add(now, NW'(run_x));
    left_set     = clip_room(run_x, now);
    pulse_set    = sat_add(now, NW'(settings.interval_ms));

    sel_dn = (preset_sel == '0) ? PW'(pct_pkg::PRESET_COUNT - 1) : preset_sel - 1'b1;
    sel_up = (preset_sel == PW'(pct_pkg::PRESET_COUNT - 1)) ? '0 : preset_sel + 1'b1;
  end

  always_comb begin
    phase_next          = phase;
    preset_sel_next     = preset_sel;
    deadline_ms_next    = deadline_ms;
    paused_left_ms_next = paused_left_ms;
    total_s_next        = total_s;
    next_pulse_ms_next  = next_pulse_ms;
    left_new            = left_old;
    force_show          = 1'b0;
    tick_check          = 1'b0;
    progress_base       = 1'b0;
    pulse               = 1'b0;
    notice              = pct_pkg::NT_NONE;

    if (op == pct_pkg::OP_TICK) begin
      if (phase == pct_pkg::PH_RUN) begin
        if (!run_live) begin
          phase_next         = pct_pkg::PH_ALARM;
          next_pulse_ms_next = pulse_set;
          progress_base      = 1'b1;
          pulse              = 1'b1;
        end else begin
          tick_check = 1'b1;
        end
      end else if (phase == pct_pkg::PH_ALARM && now >= next_pulse_ms) begin
        next_pulse_ms_next = pulse_set;
        pulse              = 1'b1;
      end
    end else begin
      case (phase)
        pct_pkg::PH_ALARM: begin
          phase_next = pct_pkg::PH_SELECT;
          notice     = pct_pkg::NT_ACKED;
          left_new   = '0;
        end
        pct_pkg::PH_SELECT: begin
          case (op)
            pct_pkg::OP_DOWN: begin
              preset_sel_next = sel_dn;
              notice          = pct_pkg::NT_PRESET;
            end
            pct_pkg::OP_UP: begin
              preset_sel_next = sel_up;
              notice          = pct_pkg::NT_PRESET;
            end
            default: begin
              total_s_next        = sel_secs;
              deadline_ms_next    = deadline_set;
              paused_left_ms_next = '0;
              phase_next          = pct_pkg::PH_RUN;
              left_new            = left_set;
              notice              = pct_pkg::NT_STARTED;
              force_show          = 1'b1;
            end
          endcase
        end
        default: begin
          case (op)
            pct_pkg::OP_DOWN: begin
              phase_next = pct_pkg::PH_SELECT;
              notice     = pct_pkg::NT_CANCELLED;
              left_new   = '0;
            end
            pct_pkg::OP_UP: begin
              if (phase == pct_pkg::PH_RUN) begin
                deadline_ms_next = deadline_set;
                left_new         = left_set;
              end else begin
                paused_left_ms_next = pause_add;
                left_new            = pause_add;
              end
              total_s_next = total_add;
              notice       = pct_pkg::NT_ADJUSTED;
              force_show   = 1'b1;
            end
            default: begin
              if (phase == pct_pkg::PH_RUN) begin
                paused_left_ms_next = left_old;
                phase_next          = pct_pkg::PH_PAUSE;
                notice              = pct_pkg::NT_PAUSED;
              end else begin
                deadline_ms_next = deadline_set;
                phase_next       = pct_pkg::PH_RUN;
                left_new         = left_set;
                notice           = pct_pkg::NT_RESUMED;
              end
              force_show = 1'b1;
            end
          endcase
        end
      endcase
    end
  end

  assign remaining = ceil_sec(left_new);

  always_comb begin
    last_second_next       = last_second;
    last_second_valid_next = last_second_valid;
    progress               = progress_base;
    if (force_show || (tick_check && (!last_second_valid || remaining != last_second)))
    begin
      last_second_next       = remaining;
      last_second_valid_next = 1'b1;
      progress               = 1'b1;
    end
    shown_secs = (phase_next == pct_pkg::PH_SELECT) ?
                 ((preset_sel_next == PW'(0)) ? settings.preset_a_s :
                  (preset_sel_next == PW'(1)) ? settings.preset_b_s :
                                                settings.preset_c_s) :
                 total_s_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= pct_pkg::PH_SELECT;
      preset_sel        <= '0;
      deadline_ms       <= '0;
      paused_left_ms    <= '0;
      total_s           <= '0;
      next_pulse_ms     <= '0;
      last_second       <= '0;
      last_second_valid <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      preset_sel        <= preset_sel_next;
      deadline_ms       <= deadline_ms_next;
      paused_left_ms    <= paused_left_ms_next;
      total_s           <= total_s_next;
      next_pulse_ms     <= next_pulse_ms_next;
      last_second       <= last_second_next;
      last_second_valid <= last_second_valid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.phase             <= phase_next;
      result.preset_index      <= preset_sel_next;
      result.remaining_seconds <= remaining;
      result.total_seconds     <= shown_secs;
      result.progress_shown    <= progress;
      result.alarm_pulse       <= pulse;
      result.notice            <= notice;
    end
  end

endmodule

@@ design/pct_cfg.sv @@
// pct_cfg: configuration register file of the preset countdown timer.
// Keeps millisecond copies of the add and limit values. Depends on pct_pkg.
`timescale 1ns / 1ps

module pct_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  pct_pkg::cfg_reg_t           cfg_index,
  input  logic [pct_pkg::SEC_W-1:0]   cfg_data,
  output pct_pkg::settings_t          settings
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      settings.preset_a_s  <= pct_pkg::RST_PRESET_A;
      settings.preset_b_s  <= pct_pkg::RST_PRESET_B;
      settings.preset_c_s  <= pct_pkg::RST_PRESET_C;
      settings.added_s     <= pct_pkg::RST_ADDED;
      settings.maximum_s   <= pct_pkg::RST_MAXIMUM;
      settings.interval_ms <= pct_pkg::RST_INTERVAL;
      settings.added_ms    <= pct_pkg::sec_to_ms(pct_pkg::RST_ADDED);
      settings.maximum_ms  <= pct_pkg::sec_to_ms(pct_pkg::RST_MAXIMUM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pct_pkg::CFG_PRESET_A: settings.preset_a_s <= cfg_data;
        pct_pkg::CFG_PRESET_B: settings.preset_b_s <= cfg_data;
        pct_pkg::CFG_PRESET_C: settings.preset_c_s <= cfg_data;
        pct_pkg::CFG_ADDED: begin
          settings.added_s  <= cfg_data;
          settings.added_ms <= pct_pkg::sec_to_ms(cfg_data);
        end
        pct_pkg::CFG_MAXIMUM: begin
          settings.maximum_s  <= cfg_data;
          settings.maximum_ms <= pct_pkg::sec_to_ms(cfg_data);
        end
        pct_pkg::CFG_INTERVAL: settings.interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/pct_checker.sv @@
// pct_checker: port-level assertions for preset_countdown_timer, bound to the top level.
// Depends on pct_pkg.
`timescale 1ns / 1ps

module pct_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  logic              result_valid,
  input  logic              result_stall,
  input  pct_pkg::result_t  result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transaction changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a waiting result");

  a_idle_remaining: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.phase == pct_pkg::PH_SELECT ||
                     result.phase == pct_pkg::PH_ALARM)
    |-> result.remaining_seconds == '0)
    else $error("remaining time shown outside running and paused");

  a_pulse_alarm: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.alarm_pulse |-> result.phase == pct_pkg::PH_ALARM)
    else $error("alarm pulse outside alarm phase");

  a_start_shows: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.notice == pct_pkg::NT_STARTED
    |-> result.phase == pct_pkg::PH_RUN && result.progress_shown)
    else $error("start without running phase and progress");

endmodule

bind preset_countdown_timer pct_checker u_pct_checker (.*);

@@ bench/preset_countdown_timer_tb.sv @@
// preset_countdown_timer_tb: self-checking bench for the preset countdown timer.
// Sends tick and button transactions in random bursts against a stalling receiver, predicts
// each result in-bench and compares it field by field. Depends on pct_pkg and the timer RTL.
`timescale 1ns / 1ps

module preset_countdown_timer_tb;
  import pct_pkg::*;

  localparam longint unsigned TIME_MAX = 64'h0000_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    opcode_t           op;
    longint unsigned   stamp;
    result_t           want;
    cfg_reg_t          idx;
    logic [SEC_W-1:0]  data;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  item_t            item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_reg_t         cfg_index = CFG_PRESET_A;
  logic [SEC_W-1:0] cfg_data = '0;

  // in-bench copy of the timer state and settings
  logic [SEC_W-1:0] timer_cfg [6] = '{RST_PRESET_A, RST_PRESET_B, RST_PRESET_C,
                                      RST_ADDED, RST_MAXIMUM, RST_INTERVAL};
  phase_t           ph = PH_SELECT;
  logic [SEL_W-1:0] sel = '0;
  longint unsigned  deadline = 0;
  longint unsigned  paused_left = 0;
  longint unsigned  total = 0;
  longint unsigned  next_pulse = 0;
  longint unsigned  shown_sec = 0;
  bit               shown_ok = 1'b0;

  result_t          pending_results [$];
  result_t          want_res;
  row_t             script [$];
  int               mismatches = 0;
  int               burst_left = 0;
  int               stall_age = 0;
  int               stall_mode = 0;
  longint unsigned  wall_ms = 0;

  preset_countdown_timer uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned sat_time(longint unsigned t);
    return (t > TIME_MAX) ? TIME_MAX : t;
  endfunction

  function automatic longint unsigned min_ms(longint unsigned a, longint unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint unsigned ceil_s(longint unsigned ms);
    return (ms + CEIL_BIAS) / MS_PER_S;
  endfunction

  function automatic longint unsigned preset_len(logic [SEL_W-1:0] s);
    if (s == 2'd0) return timer_cfg[CFG_PRESET_A];
    if (s == 2'd1) return timer_cfg[CFG_PRESET_B];
    return timer_cfg[CFG_PRESET_C];
  endfunction

  function automatic longint unsigned ms_left(longint unsigned now);
    longint unsigned d;
    if (ph == PH_PAUSE) return paused_left;
    if (ph != PH_RUN || now >= deadline) return 0;
    d = deadline - now;
    return (d > LEFT_CAP) ? LEFT_CAP : d;
  endfunction

  function automatic result_t predict_timer(item_t it);
    longint unsigned now, secs, add_ms, max_ms;
    bit force_show;
    result_t res;
    now = it.now_ms;
    force_show = 1'b0;
    res = '0;
    add_ms = timer_cfg[CFG_ADDED] * MS_PER_S;
    max_ms = timer_cfg[CFG_MAXIMUM] * MS_PER_S;
    if (it.opcode == OP_TICK) begin
      if (ph == PH_RUN) begin
        if (now >= deadline) begin
          ph = PH_ALARM;
          next_pulse = sat_time(now + timer_cfg[CFG_INTERVAL]);
          res.progress_shown = 1'b1;
          res.alarm_pulse = 1'b1;
        end else begin
          secs = ceil_s(ms_left(now));
          if (!shown_ok || secs != shown_sec) begin
            shown_sec = secs;
            shown_ok = 1'b1;
            res.progress_shown = 1'b1;
          end
        end
      end else if (ph == PH_ALARM && now >= next_pulse) begin
        next_pulse = sat_time(now + timer_cfg[CFG_INTERVAL]);
        res.alarm_pulse = 1'b1;
      end
    end else if (ph == PH_ALARM) begin
      ph = PH_SELECT;
      res.notice = NT_ACKED;
    end else if (ph == PH_SELECT) begin
      case (it.opcode)
        OP_DOWN: begin
          sel = (sel == 0) ? SEL_W'(PRESET_COUNT - 1) : sel - 1'b1;
          res.notice = NT_PRESET;
        end
        OP_UP: begin
          sel = SEL_W'((sel + 1) % PRESET_COUNT);
          res.notice = NT_PRESET;
        end
        default: begin
          total = preset_len(sel) * MS_PER_S;
          deadline = sat_time(now + total);
          paused_left = 0;
          ph = PH_RUN;
          shown_ok = 1'b0;
          res.notice = NT_STARTED;
          force_show = 1'b1;
        end
      endcase
    end else begin
      case (it.opcode)
        OP_DOWN: begin
          ph = PH_SELECT;
          res.notice = NT_CANCELLED;
        end
        OP_UP: begin
          if (ph == PH_RUN) deadline = sat_time(now + min_ms(ms_left(now) + add_ms, max_ms));
          else paused_left = min_ms(paused_left + add_ms, max_ms);
          total = min_ms(total + add_ms, max_ms);
          shown_ok = 1'b0;
          res.notice = NT_ADJUSTED;
          force_show = 1'b1;
        end
        default: begin
          if (ph == PH_RUN) begin
            paused_left = ms_left(now);
            ph = PH_PAUSE;
            res.notice = NT_PAUSED;
          end else begin
            deadline = sat_time(now + paused_left);
            ph = PH_RUN;
            res.notice = NT_RESUMED;
          end
          force_show = 1'b1;
        end
      endcase
    end
    if (force_show) begin
      shown_sec = ceil_s(ms_left(now));
      shown_ok = 1'b1;
      res.progress_shown = 1'b1;
    end
    res.phase = ph;
    res.preset_index = sel;
    res.remaining_seconds = SEC_W'(ceil_s(ms_left(now)));
    res.total_seconds = (ph == PH_SELECT) ? SEC_W'(preset_len(sel)) : SEC_W'(ceil_s(total));
    return res;
  endfunction

  function automatic row_t stim(opcode_t op, longint unsigned stamp);
    row_t r;
    r.kind = ROW_ITEM;
    r.op = op;
    r.stamp = stamp;
    r.want = '0;
    r.idx = CFG_PRESET_A;
    r.data = '0;
    return r;
  endfunction

  function automatic row_t stim_chk(opcode_t op, longint unsigned stamp, result_t want);
    row_t r;
    r = stim(op, stamp);
    r.kind = ROW_CHECKED;
    r.want = want;
    return r;
  endfunction

  function automatic row_t reg_row(cfg_reg_t idx, logic [SEC_W-1:0] data);
    row_t r;
    r = stim(OP_TICK, 0);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [SEC_W-1:0] pick_setting(int p, cfg_reg_t r);
    if (p == 1) return 16'hFFFF;
    if (p == 2) return 16'd1;
    case (r)
      CFG_ADDED:
        return ($urandom_range(0, 9) == 0) ? SEC_W'($urandom) : SEC_W'($urandom_range(1, 4));
      CFG_MAXIMUM:
        return ($urandom_range(0, 5) == 0) ? 16'hFFFF : SEC_W'($urandom_range(1, 12));
      CFG_INTERVAL:
        return SEC_W'($urandom_range(0, 2500));
      default:
        return ($urandom_range(0, 9) == 0) ? SEC_W'($urandom) : SEC_W'($urandom_range(0, 6));
    endcase
  endfunction

  // opcode mix follows the predicted phase so that runs reach expiry and the alarm
  function automatic item_t next_item();
    item_t it;
    int roll;
    longint unsigned step;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_SELECT: it.opcode = (roll < 15) ? OP_TICK : (roll < 30) ? OP_DOWN :
                             (roll < 45) ? OP_UP : OP_CONFIRM;
      PH_RUN:    it.opcode = (roll < 78) ? OP_TICK : (roll < 83) ? OP_DOWN :
                             (roll < 90) ? OP_UP : OP_CONFIRM;
      PH_PAUSE:  it.opcode = (roll < 25) ? OP_TICK : (roll < 35) ? OP_DOWN :
                             (roll < 50) ? OP_UP : OP_CONFIRM;
      default:   it.opcode = (roll < 70) ? OP_TICK : (roll < 80) ? OP_DOWN :
                             (roll < 90) ? OP_UP : OP_CONFIRM;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      wall_ms = {$urandom, $urandom} & TIME_MAX;
    end else if (roll < 4) begin
      step = $urandom_range(0, 5000);
      wall_ms = (wall_ms > step) ? wall_ms - step : 0;
    end else if (roll < 5) begin
      wall_ms = TIME_MAX - $urandom_range(0, 3000);
    end else if (roll < 15) begin
      wall_ms = sat_time(wall_ms + $urandom_range(0, 80000000));
    end else begin
      wall_ms = sat_time(wall_ms + $urandom_range(0, 1500));
    end
    it.now_ms = NOW_W'(wall_ms);
    return it;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t typed_res);
    result_t predicted;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = predict_timer(it);
    pending_results.push_back(typed ? typed_res : predicted);
    burst_left--;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [SEC_W-1:0] val, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timer_cfg[idx] = val;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %p", $time, result);
          mismatches++;
        end else begin
          want_res = pending_results.pop_front();
          compare_field("phase", want_res.phase, result.phase);
          compare_field("preset_index", want_res.preset_index, result.preset_index);
          compare_field("remaining_seconds", want_res.remaining_seconds,
                        result.remaining_seconds);
          compare_field("total_seconds", want_res.total_seconds, result.total_seconds);
          compare_field("progress_shown", want_res.progress_shown, result.progress_shown);
          compare_field("alarm_pulse", want_res.alarm_pulse, result.alarm_pulse);
          compare_field("notice", want_res.notice, result.notice);
        end
      end
      stall_age++;
      if (stall_age % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= $urandom_range(0, 1);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= ((stall_age % 7) < 3);
      endcase
    end
  end

  initial begin
    script = '{
      stim_chk(OP_TICK, 0, '{PH_SELECT, 2'd0, 16'd0, 16'd60, 1'b0, 1'b0, NT_NONE}),
      stim_chk(OP_DOWN, 0, '{PH_SELECT, 2'd2, 16'd0, 16'd300, 1'b0, 1'b0, NT_PRESET}),
      stim_chk(OP_UP, 0, '{PH_SELECT, 2'd0, 16'd0, 16'd60, 1'b0, 1'b0, NT_PRESET}),
      stim(OP_UP, 0),
      stim_chk(OP_CONFIRM, 1000, '{PH_RUN, 2'd1, 16'd180, 16'd180, 1'b1, 1'b0, NT_STARTED}),
      stim_chk(OP_TICK, 1000, '{PH_RUN, 2'd1, 16'd180, 16'd180, 1'b0, 1'b0, NT_NONE}),
      stim(OP_TICK, 2000),
      stim(OP_CONFIRM, 3000),
      stim(OP_TICK, 9000),
      stim(OP_UP, 9500),
      stim(OP_CONFIRM, 10000),
      stim(OP_UP, 20000),
      stim(OP_TICK, TIME_MAX),
      stim(OP_TICK, TIME_MAX),
      stim_chk(OP_DOWN, 0, '{PH_SELECT, 2'd1, 16'd0, 16'd180, 1'b0, 1'b0, NT_ACKED}),
      stim(OP_CONFIRM, TIME_MAX - 5),
      stim(OP_TICK, 0),
      stim_chk(OP_DOWN, 0, '{PH_SELECT, 2'd1, 16'd0, 16'd180, 1'b0, 1'b0, NT_CANCELLED}),
      reg_row(CFG_MAXIMUM, 16'd100),
      reg_row(CFG_ADDED, 16'd200),
      stim(OP_CONFIRM, 5000),
      stim(OP_UP, 5000),
      stim(OP_DOWN, 5000),
      reg_row(CFG_PRESET_B, 16'd0),
      reg_row(CFG_INTERVAL, 16'd0),
      stim_chk(OP_CONFIRM, 7000, '{PH_RUN, 2'd1, 16'd0, 16'd0, 1'b1, 1'b0, NT_STARTED}),
      stim(OP_CONFIRM, 7000),
      stim(OP_CONFIRM, 7000),
      stim_chk(OP_TICK, 7000, '{PH_ALARM, 2'd1, 16'd0, 16'd0, 1'b1, 1'b1, NT_NONE}),
      stim(OP_TICK, 7000),
      stim(OP_CONFIRM, 7000)
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < script.size(); i++) begin
      if (script[i].kind == ROW_CFG) begin
        if (i == 0 || script[i-1].kind != ROW_CFG) wait_idle();
        write_reg(script[i].idx, script[i].data,
                  i == script.size() - 1 || script[i+1].kind != ROW_CFG);
      end else begin
        send_item('{script[i].op, NOW_W'(script[i].stamp)}, script[i].kind == ROW_CHECKED,
                  script[i].want);
      end
    end
    wall_ms = 100000;
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      for (int r = 0; r < 6; r++) write_reg(cfg_reg_t'(r), pick_setting(p, cfg_reg_t'(r)), r == 5);
      repeat (50) send_item(next_item(), 1'b0, '0);
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
design/pct_pkg.sv
design/pct_cfg.sv
design/preset_countdown_timer.sv
design/pct_checker.sv
bench/preset_countdown_timer_tb.sv
